>>> hw/rtl/lesf_pkg.sv
// Shared types, constants and luma function for the Laplacian edge stream filter.
`timescale 1ns / 1ps
`default_nettype none

package lesf_pkg;

    localparam int PIX_W     = 24;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int LUMA_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd800;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd600;

    // BT.601-style luma weights, sum is 256
    localparam logic [7:0] COEF_R = 8'd77;
    localparam logic [7:0] COEF_G = 8'd150;
    localparam logic [7:0] COEF_B = 8'd29;

    localparam logic [LUMA_W-1:0] LUMA_MAX = 8'hff;

    // Item between the input register and the window stage
    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic              zero_edge;
        logic              first;
        logic              row_end;
    } stage_t;

    // Result held in the output register
    typedef struct packed {
        logic [LUMA_W-1:0] level;
        logic              first;
        logic              row_end;
    } result_t;

    // Y = (77R + 150G + 29B) >> 8
    function automatic logic [LUMA_W-1:0] luma_of(input logic [PIX_W-1:0] rgb);
        logic [15:0] sum;
        sum = 16'(COEF_R) * 16'(rgb[23:16])
            + 16'(COEF_G) * 16'(rgb[15:8])
            + 16'(COEF_B) * 16'(rgb[7:0]);
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lesf_if.sv
// Stream and configuration channel interfaces of the Laplacian edge stream filter.
`timescale 1ns / 1ps
`default_nettype none

// Input pixel stream
interface lesf_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic [lesf_pkg::PIX_W-1:0]  pixel_rgb;
    logic                        start_mark;

    modport source (output valid, output pixel_rgb, output start_mark, input ready);
    modport sink   (input valid, input pixel_rgb, input start_mark, output ready);
endinterface

// Output edge stream
interface lesf_pix_out_if;
    logic                        valid;
    logic                        ready;
    logic [lesf_pkg::PIX_W-1:0]  edge_rgb;
    logic                        first_of_frame;
    logic                        row_end;

    modport source (output valid, output edge_rgb, output first_of_frame, output row_end,
                    input ready);
    modport sink   (input valid, input edge_rgb, input first_of_frame, input row_end,
                    output ready);
endinterface

// Register write channel
interface lesf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lesf_pkg::CFG_IDX_W-1:0]  index;
    logic [lesf_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/laplacian_edge_stream_filter.sv
// Path: input stage, then output register; line stores: one read, one write per cycle.
// Throughput: one pixel per cycle while the output is not stalled by back-pressure.
// Pixels before a frame-start mark are dropped and give no result.
// Reset: waits for a frame start, counters cleared, width 800 and height 600;
// line stores and window are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_stream_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    lesf_pix_in_if.sink          pix_in,
    lesf_pix_out_if.source       pix_out,
    lesf_cfg_if.sink             cfg
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (lesf_pkg::CFG_W > WCNT_W) ? lesf_pkg::CFG_W : WCNT_W;
    localparam int ROW_W  = lesf_pkg::ROW_W;

    // Configuration registers
    logic [lesf_pkg::CFG_W-1:0] frame_width_reg;
    logic [lesf_pkg::CFG_W-1:0] frame_height_reg;

    // Frame position
    logic              awaiting_reg;
    logic              awaiting_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    // Input register stage
    logic              stage_valid_reg;
    logic              stage_valid_next;
    lesf_pkg::stage_t  stage_reg;
    lesf_pkg::stage_t  stage_next;
    logic [COL_W-1:0]  addr_reg;

    logic              in_xfer;
    logic              load;
    logic              stage_take;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [EW-1:0]     eff_width;
    logic [EW-1:0]     col_inc;
    logic [ROW_W-1:0]  eff_height;
    logic [ROW_W:0]    row_inc;
    logic              last_col;
    logic              last_row;

    logic [lesf_pkg::LUMA_W-1:0] col_top;
    logic [lesf_pkg::LUMA_W-1:0] col_mid;
    logic                        out_valid;
    lesf_pkg::result_t           result;

    // Register writes, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= lesf_pkg::RESET_FRAME_WIDTH;
            frame_height_reg <= lesf_pkg::RESET_FRAME_HEIGHT;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == lesf_pkg::REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg.data;
            end
            if (cfg.index == lesf_pkg::REG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg.data;
            end
        end
    end

    // Input handshake: take a pixel when the stage is empty or moving on
    assign pix_in.ready = ~stage_valid_reg | stage_take;
    assign in_xfer      = pix_in.valid & pix_in.ready;
    assign load         = in_xfer & (~awaiting_reg | pix_in.start_mark);

    // Position of this pixel and row/frame end detection
    always_comb
    begin
        cur_col = awaiting_reg ? '0 : col_reg;
        cur_row = awaiting_reg ? '0 : row_reg;

        if (frame_width_reg == '0)
        begin
            eff_width = EW'(1);
        end
        else if (EW'(frame_width_reg) > EW'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW'(frame_width_reg);
        end
        eff_height = (frame_height_reg == '0) ? ROW_W'(1) : frame_height_reg;

        col_inc  = EW'(cur_col) + EW'(1);
        row_inc  = {1'b0, cur_row} + (ROW_W+1)'(1);
        last_col = col_inc >= eff_width;
        last_row = row_inc >= {1'b0, eff_height};
    end

    // Counter update on every pixel that enters the frame
    always_comb
    begin
        awaiting_next = awaiting_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (load)
        begin
            awaiting_next = 1'b0;
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next      = '0;
                    awaiting_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb
    begin
        stage_next.luma      = lesf_pkg::luma_of(pix_in.pixel_rgb);
        stage_next.zero_edge = (cur_col < COL_W'(2)) | (cur_row < ROW_W'(2));
        stage_next.first     = (cur_col == '0) & (cur_row == '0);
        stage_next.row_end   = last_col;
    end

    always_comb
    begin
        if (load)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_take)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg    <= 1'b1;
            col_reg         <= '0;
            row_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg    <= awaiting_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
            addr_reg  <= cur_col;
        end
    end

    // Line stores: read at transfer, write back when the stage moves on
    lesf_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (load),
        .rd_addr  (cur_col),
        .wr_en    (stage_take),
        .wr_addr  (addr_reg),
        .wr_luma  (stage_reg.luma),
        .rd_older (col_top),
        .rd_newer (col_mid)
    );

    // Window, Laplacian and output register
    lesf_laplace u_laplace (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .stage       (stage_reg),
        .col_top     (col_top),
        .col_mid     (col_mid),
        .out_ready   (pix_out.ready),
        .stage_take  (stage_take),
        .out_valid   (out_valid),
        .result      (result)
    );

    assign pix_out.valid          = out_valid;
    assign pix_out.edge_rgb       = {result.level, result.level, result.level};
    assign pix_out.first_of_frame = result.first;
    assign pix_out.row_end        = result.row_end;

endmodule

`default_nettype wire

>>> hw/rtl/lesf_line_store.sv
// Two line stores of luma with registered read and same-address forwarding.
`timescale 1ns / 1ps
`default_nettype none

module lesf_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [lesf_pkg::LUMA_W-1:0]   wr_luma,
    output logic      [lesf_pkg::LUMA_W-1:0]   rd_older,
    output logic      [lesf_pkg::LUMA_W-1:0]   rd_newer
);

    logic [lesf_pkg::LUMA_W-1:0] older_mem [DEPTH];
    logic [lesf_pkg::LUMA_W-1:0] newer_mem [DEPTH];

    logic [lesf_pkg::LUMA_W-1:0] older_q_reg;
    logic [lesf_pkg::LUMA_W-1:0] newer_q_reg;
    logic [lesf_pkg::LUMA_W-1:0] fwd_older_reg;
    logic [lesf_pkg::LUMA_W-1:0] fwd_newer_reg;
    logic                        fwd_reg;
    logic                        fwd_next;

    // Read and write hit one entry at the same edge: memory returns old data
    assign fwd_next = rd_en & wr_en & (rd_addr == wr_addr);

    // Row shift: the row one up moves to the row two up, new luma takes its place
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= rd_newer;
            newer_mem[wr_addr] <= wr_luma;
        end
        if (rd_en)
        begin
            older_q_reg   <= older_mem[rd_addr];
            newer_q_reg   <= newer_mem[rd_addr];
            fwd_older_reg <= rd_newer;
            fwd_newer_reg <= wr_luma;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_older = fwd_reg ? fwd_older_reg : older_q_reg;
    assign rd_newer = fwd_reg ? fwd_newer_reg : newer_q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lesf_laplace.sv
// 3x3 luma window, clamped 8-neighbor Laplacian and output register.
`timescale 1ns / 1ps
`default_nettype none

module lesf_laplace (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          stage_valid,
    input  wire lesf_pkg::stage_t              stage,
    input  wire logic [lesf_pkg::LUMA_W-1:0]   col_top,
    input  wire logic [lesf_pkg::LUMA_W-1:0]   col_mid,
    input  wire logic                          out_ready,
    output logic                               stage_take,
    output logic                               out_valid,
    output lesf_pkg::result_t                  result
);

    // [row*2 + col], col 0 is the oldest column
    logic [lesf_pkg::LUMA_W-1:0] win_reg [6];
    logic [lesf_pkg::LUMA_W-1:0] col_new [3];

    logic                        out_valid_reg;
    logic                        out_valid_next;
    lesf_pkg::result_t           result_reg;
    lesf_pkg::result_t           result_next;

    logic [10:0]                 centre_x8;
    logic [10:0]                 ring_sum;
    logic signed [11:0]          diff;
    logic [lesf_pkg::LUMA_W-1:0] clamped;

    assign col_new[0] = col_top;
    assign col_new[1] = col_mid;
    assign col_new[2] = stage.luma;

    // Stage moves on when the output register is empty or drains this cycle
    assign stage_take = stage_valid & (~out_valid_reg | out_ready);

    // Laplacian: 8 * centre minus the eight neighbors, clamp to 0..255
    always_comb
    begin
        centre_x8 = {win_reg[3], 3'b000};
        ring_sum  = 11'(win_reg[0]) + 11'(win_reg[1]) + 11'(col_new[0])
                  + 11'(win_reg[2]) + 11'(col_new[1])
                  + 11'(win_reg[4]) + 11'(win_reg[5]) + 11'(col_new[2]);
        diff      = $signed({1'b0, centre_x8}) - $signed({1'b0, ring_sum});
        if (diff < 12'sd0)
        begin
            clamped = '0;
        end
        else if (diff > 12'sd255)
        begin
            clamped = lesf_pkg::LUMA_MAX;
        end
        else
        begin
            clamped = diff[7:0];
        end
    end

    always_comb
    begin
        result_next.level   = stage.zero_edge ? '0 : clamped;
        result_next.first   = stage.first;
        result_next.row_end = stage.row_end;
    end

    always_comb
    begin
        if (stage_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Window shift and result capture
    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[2*k]     <= win_reg[2*k+1];
                win_reg[2*k + 1] <= col_new[k];
            end
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the Laplacian edge stream filter: table-driven and random frames.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int LINE_MAX       = 2048;
    localparam int RANDOM_ITEMS   = 340;
    localparam int TAIL_CYCLES    = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_CYCLES = 400_000;

    // One output transfer as the checker sees it
    typedef struct packed {
        logic [lesf_pkg::PIX_W-1:0] rgb;
        logic                       first;
        logic                       last;
    } filt_out_t;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

    // One row of the directed table; typed rows carry their result by hand
    typedef struct packed {
        row_kind_t                  kind;
        logic [lesf_pkg::PIX_W-1:0] rgb;
        logic                       start;
        logic [lesf_pkg::CFG_W-1:0] value;
        logic                       typed;
        logic                       yields;
        filt_out_t                  want;
    } stim_row_t;

    typedef enum int {LOOK_NOISE, LOOK_FLAT, LOOK_BINARY, LOOK_SPIKES} look_t;

    logic clk;
    logic rst_n;

    lesf_pix_in_if  pix_in();
    lesf_pix_out_if pix_out();
    lesf_cfg_if     cfg();

    laplacian_edge_stream_filter #(
        .MAX_WIDTH (LINE_MAX)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    // Filter model state
    logic [lesf_pkg::CFG_W-1:0]  model_width;
    logic [lesf_pkg::CFG_W-1:0]  model_height;
    bit                          waiting_start;
    int                          col_cnt;
    int                          row_cnt;
    logic [lesf_pkg::LUMA_W-1:0] line_older [LINE_MAX];
    logic [lesf_pkg::LUMA_W-1:0] line_newer [LINE_MAX];
    logic [lesf_pkg::LUMA_W-1:0] win [6];

    filt_out_t expected_q [$];
    stim_row_t dir_rows [$];

    // Run bookkeeping
    int  fail_count;
    int  checked_results;
    int  results_made;
    int  dropped_items;
    int  reg_writes;
    int  holds_done;
    bit  gaps_on;
    bit  hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    function automatic int eff_width();
        if (model_width == '0)
            return 1;
        if (model_width > LINE_MAX)
            return LINE_MAX;
        return int'(model_width);
    endfunction

    // Model one input transfer; returns 1 when it makes a result
    function automatic bit filter_pixel(input logic [lesf_pkg::PIX_W-1:0] rgb,
                                        input logic start, output filt_out_t res);
        int wd;
        int ht;
        int x;
        int luma;
        int lap;
        int k;
        int m;
        int nb [3][3];
        bit last_col;
        bit last_row;
        wd  = eff_width();
        ht  = (model_height == '0) ? 1 : int'(model_height);
        res = '0;
        if (waiting_start)
        begin
            if (!start)
                return 1'b0;
            waiting_start = 1'b0;
            col_cnt       = 0;
            row_cnt       = 0;
        end
        x    = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
        luma = (77 * int'(rgb[23:16]) + 150 * int'(rgb[15:8]) + 29 * int'(rgb[7:0])) >> 8;

        // shift the 3x3 window: two stored columns plus the line stores and new luma
        for (k = 0; k < 3; k++)
        begin
            nb[k][0] = int'(win[2 * k]);
            nb[k][1] = int'(win[2 * k + 1]);
        end
        nb[0][2] = int'(line_older[x]);
        nb[1][2] = int'(line_newer[x]);
        nb[2][2] = luma;
        for (k = 0; k < 3; k++)
        begin
            win[2 * k]     = nb[k][1][lesf_pkg::LUMA_W-1:0];
            win[2 * k + 1] = nb[k][2][lesf_pkg::LUMA_W-1:0];
        end
        line_older[x] = line_newer[x];
        line_newer[x] = luma[lesf_pkg::LUMA_W-1:0];

        // 8*centre minus neighbours = 9*centre minus the whole window
        lap = 9 * nb[1][1];
        for (k = 0; k < 3; k++)
            for (m = 0; m < 3; m++)
                lap -= nb[k][m];
        if (lap < 0)
            lap = 0;
        else if (lap > 255)
            lap = 255;

        res.rgb   = (col_cnt < 2 || row_cnt < 2) ? '0 : {3{lap[7:0]}};
        res.first = (col_cnt == 0 && row_cnt == 0);
        last_col  = (col_cnt + 1 >= wd);
        last_row  = (row_cnt + 1 >= ht);
        res.last  = last_col;

        if (last_col)
        begin
            col_cnt = 0;
            if (last_row)
            begin
                row_cnt       = 0;
                waiting_start = 1'b1;
            end
            else
                row_cnt = row_cnt + 1;
        end
        else
            col_cnt = col_cnt + 1;
        return 1'b1;
    endfunction

    function automatic stim_row_t pixel_row(input logic [lesf_pkg::PIX_W-1:0] rgb,
                                            input logic start);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_PIXEL;
        r.rgb   = rgb;
        r.start = start;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [lesf_pkg::PIX_W-1:0] rgb,
                                            input logic start, input logic yields,
                                            input logic [lesf_pkg::PIX_W-1:0] out_rgb,
                                            input logic first, input logic last);
        stim_row_t r;
        r            = pixel_row(rgb, start);
        r.typed      = 1'b1;
        r.yields     = yields;
        r.want.rgb   = out_rgb;
        r.want.first = first;
        r.want.last  = last;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input row_kind_t kind,
                                          input logic [lesf_pkg::CFG_W-1:0] value);
        stim_row_t r;
        r       = '0;
        r.kind  = kind;
        r.value = value;
        return r;
    endfunction

    function automatic logic [lesf_pkg::PIX_W-1:0] make_rgb(input look_t look,
                                                            input logic [23:0] base);
        case (look)
            LOOK_FLAT:   return base ^ (24'($urandom) & 24'h1f1f1f);
            LOOK_BINARY: return ($urandom_range(1) == 0) ? 24'h000000 : 24'hffffff;
            LOOK_SPIKES: return ($urandom_range(9) == 0) ? 24'($urandom)
                                                         : base ^ (24'($urandom) & 24'h070707);
            default:     return 24'($urandom);
        endcase
    endfunction

    function automatic void report_failure(input string what, input filt_out_t want_r,
                                           input filt_out_t got_r);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected rgb %06h first %b row_end %b, %s %06h first %b row_end %b",
                     $realtime, what, want_r.rgb, want_r.first, want_r.last,
                     "got rgb", got_r.rgb, got_r.first, got_r.last);
    endfunction

    // Offer one pixel, wait for its transfer, then record what it should produce
    task automatic send_item(input stim_row_t row);
        filt_out_t pred;
        bit        got;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 21)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.pixel_rgb  <= row.rgb;
        pix_in.start_mark <= row.start;
        do
            @(posedge clk);
        while (pix_in.ready !== 1'b1);
        got = filter_pixel(row.rgb, row.start, pred);
        if (row.typed)
        begin
            got  = row.yields;
            pred = row.want;
        end
        if (got)
        begin
            expected_q.push_back(pred);
            results_made++;
        end
        else
            dropped_items++;
    endtask

    // Stop offering pixels and let the block empty out
    task automatic wait_drained();
        @(negedge clk);
        pix_in.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [lesf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lesf_pkg::CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        if (idx == lesf_pkg::REG_FRAME_WIDTH)
            model_width = value;
        else if (idx == lesf_pkg::REG_FRAME_HEIGHT)
            model_height = value;
        reg_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // One frame of random content; split_at picks a pixel before which the frame is reshaped
    task automatic send_frame(input look_t look, input int split_at);
        logic [lesf_pkg::PIX_W-1:0] base;
        int                         n;
        base = 24'($urandom);
        n    = 0;
        send_item(pixel_row(make_rgb(look, base), 1'b1));
        while (!waiting_start)
        begin
            n++;
            if (n == split_at)
            begin
                // only shrink the width past row 0 so every line store entry read was written
                if ($urandom_range(1) == 0)
                    set_register(lesf_pkg::REG_FRAME_WIDTH,
                                 (row_cnt == 0) ? 12'($urandom_range(1, 12))
                                                : 12'($urandom_range(1, eff_width())));
                else
                    set_register(lesf_pkg::REG_FRAME_HEIGHT, 12'($urandom_range(1, 6)));
            end
            send_item(pixel_row(make_rgb(look, base), $urandom_range(99) < 4));
        end
    endtask

    // Output side: random back-pressure plus one long hold-off on request
    initial
    begin
        pix_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
                pix_out.ready <= gaps_on ? ($urandom_range(99) >= 21) : 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin : check_results
        filt_out_t got_r;
        filt_out_t want_r;
        if (rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1)
        begin
            got_r.rgb   = pix_out.edge_rgb;
            got_r.first = pix_out.first_of_frame;
            got_r.last  = pix_out.row_end;
            if (expected_q.size() == 0)
                report_failure("result with nothing expected", '0, got_r);
            else
            begin
                want_r = expected_q.pop_front();
                checked_results++;
                if (got_r.rgb !== want_r.rgb || got_r.first !== want_r.first
                    || got_r.last !== want_r.last)
                    report_failure("result mismatch", want_r, got_r);
            end
        end
    end

    // Directed table: reset behavior, mid-frame reshaping, clamp at both ends
    function automatic void load_directed();
        int i;
        logic [lesf_pkg::PIX_W-1:0] mixed [9];
        mixed = '{24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00, 24'h000000,
                  24'h00ffff, 24'hff00ff, 24'h808080, 24'h7f7f7f};
        // nothing passes before a frame start
        dir_rows.push_back(typed_row(24'hffffff, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(24'h123456, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        // frame start with the reset width of 800, then a start mark inside the frame
        dir_rows.push_back(typed_row(24'hffffff, 1'b1, 1'b1, '0, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(24'h000000, 1'b1, 1'b1, '0, 1'b0, 1'b0));
        // shrink to 2x2 while already past the new last column: row ends at once
        dir_rows.push_back(reg_row(ROW_WIDTH, 12'd2));
        dir_rows.push_back(reg_row(ROW_HEIGHT, 12'd2));
        dir_rows.push_back(typed_row(24'h00ff00, 1'b0, 1'b1, '0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(24'h0000ff, 1'b0, 1'b1, '0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(24'hff0000, 1'b0, 1'b1, '0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(24'habcdef, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        // 3x3 frame, white centre on black: saturates high at the only inner pixel
        dir_rows.push_back(reg_row(ROW_WIDTH, 12'd3));
        dir_rows.push_back(reg_row(ROW_HEIGHT, 12'd3));
        for (i = 0; i < 9; i++)
            dir_rows.push_back(typed_row((i == 4) ? 24'hffffff : 24'h000000, i == 0, 1'b1,
                                         (i == 8) ? 24'hffffff : 24'h000000,
                                         i == 0, i % 3 == 2));
        // 3x3 frame, black centre in mixed colors: clamps low
        for (i = 0; i < 9; i++)
            dir_rows.push_back(pixel_row(mixed[i], i == 0));
    endfunction

    // Stimulus
    initial
    begin
        int         i;
        int         rand_start;
        int         done_items;
        bit         hold_issued;
        logic [lesf_pkg::CFG_W-1:0] wd;
        logic [lesf_pkg::CFG_W-1:0] ht;

        rst_n             = 1'b0;
        pix_in.valid      = 1'b0;
        pix_in.pixel_rgb  = '0;
        pix_in.start_mark = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = '0;
        cfg.data          = '0;
        gaps_on           = 1'b1;
        hold_req          = 1'b0;
        hold_issued       = 1'b0;
        model_width       = lesf_pkg::RESET_FRAME_WIDTH;
        model_height      = lesf_pkg::RESET_FRAME_HEIGHT;
        waiting_start     = 1'b1;
        col_cnt           = 0;
        row_cnt           = 0;
        for (i = 0; i < LINE_MAX; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        for (i = 0; i < 6; i++)
            win[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        load_directed();
        foreach (dir_rows[j])
        begin
            case (dir_rows[j].kind)
                ROW_WIDTH:  set_register(lesf_pkg::REG_FRAME_WIDTH, dir_rows[j].value);
                ROW_HEIGHT: set_register(lesf_pkg::REG_FRAME_HEIGHT, dir_rows[j].value);
                default:    send_item(dir_rows[j]);
            endcase
        end

        // zero sizes act as a 1x1 frame
        set_register(lesf_pkg::REG_FRAME_WIDTH, '0);
        set_register(lesf_pkg::REG_FRAME_HEIGHT, '0);
        repeat (3)
        begin
            send_item(pixel_row(24'($urandom), 1'b0));
            send_frame(LOOK_NOISE, -1);
        end

        // largest register values, cut short inside the frame
        set_register(lesf_pkg::REG_FRAME_WIDTH, 12'hfff);
        set_register(lesf_pkg::REG_FRAME_HEIGHT, 12'hfff);
        send_item(pixel_row(24'($urandom), 1'b1));
        repeat (15) send_item(pixel_row(24'($urandom), 1'b0));
        // column 16 is already past the new row end
        set_register(lesf_pkg::REG_FRAME_WIDTH, 12'd4);
        repeat (5) send_item(pixel_row(24'($urandom), 1'b0));
        // row 2 is already past the new frame end
        set_register(lesf_pkg::REG_FRAME_HEIGHT, 12'd2);
        while (!waiting_start)
            send_item(pixel_row(24'($urandom), 1'b0));

        // one pixel wide: every line store read hits the entry written just before
        set_register(lesf_pkg::REG_FRAME_WIDTH, 12'd1);
        set_register(lesf_pkg::REG_FRAME_HEIGHT, 12'd40);
        send_frame(LOOK_SPIKES, -1);

        // random frames
        rand_start = results_made;
        while (results_made - rand_start < RANDOM_ITEMS)
        begin
            done_items = results_made - rand_start;
            gaps_on    = !(done_items >= 200 && done_items < 280);
            if (!hold_issued && done_items >= 120)
            begin
                // a frame big enough to back up behind the held output
                set_register(lesf_pkg::REG_FRAME_WIDTH, 12'd12);
                set_register(lesf_pkg::REG_FRAME_HEIGHT, 12'd6);
                hold_req    = 1'b1;
                hold_issued = 1'b1;
            end
            else if (done_items == 0 || $urandom_range(99) < 35)
            begin
                case ($urandom_range(19))
                    0:       wd = '0;
                    1, 2:    wd = 12'($urandom_range(13, 40));
                    default: wd = 12'($urandom_range(1, 12));
                endcase
                ht = ($urandom_range(19) == 0) ? '0 : 12'($urandom_range(1, 6));
                set_register(lesf_pkg::REG_FRAME_WIDTH, wd);
                set_register(lesf_pkg::REG_FRAME_HEIGHT, ht);
            end
            repeat ($urandom_range(2))
                send_item(pixel_row(24'($urandom), 1'b0));
            send_frame(look_t'($urandom_range(3)),
                       ($urandom_range(99) < 12) ? int'($urandom_range(1, 20)) : -1);
        end
        gaps_on = 1'b1;

        wait_drained();
        $display("Covered %0d pixel transfers (%0d dropped outside frames), %0d results checked,",
                 results_made + dropped_items, dropped_items, checked_results);
        $display("%0d register writes from zero to 4095 with mid-frame reshaping, %0d hold-off.",
                 reg_writes, holds_done);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
